// ===== rtl/core/cmq_pkg.sv =====
// Shared types and constants of the closable message ring queue.
`default_nettype none

package cmq_pkg;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_SEND  = 2'd0;
    localparam logic [1:0] FUNC_RECV  = 2'd1;
    localparam logic [1:0] FUNC_CLOSE = 2'd2;

    // Status codes of a result.
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_EMPTY  = 2'd2;
    localparam logic [1:0] STAT_CLOSED = 2'd3;

    // Carrier widths of the command word; they cover the largest queue geometry.
    localparam int SLOT_IDX_W = 10;
    localparam int MEM_ADDR_W = 16;
    localparam int OFS_W      = 6;

    // Receive buffer sizes above this value act as this value.
    localparam logic [6:0] RECV_CAP = 7'd64;

    typedef enum logic [1:0] {
        CMD_RESULT = 2'b01,
        CMD_RECV   = 2'b10
    } cmd_kind_t;

    // One command from the front part to the back part.
    typedef struct packed {
        cmd_kind_t               kind;
        logic [1:0]              status;
        logic [OFS_W-1:0]        length;
        logic                    byte_we;
        logic [MEM_ADDR_W-1:0]   byte_addr;
        logic [7:0]              byte_data;
        logic                    len_we;
        logic [SLOT_IDX_W-1:0]   slot;
        logic [OFS_W-1:0]        cap;
    } cmd_t;

    // One result item as it sits in the output register.
    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic [OFS_W-1:0] length;
        logic             last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/cmq_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface cmq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       end_of_message;
    logic [6:0] buf_size;

    modport source (output valid, func, data_byte, end_of_message, buf_size, input ready);
    modport sink   (input valid, func, data_byte, end_of_message, buf_size, output ready);
endinterface

interface cmq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [5:0] length;
    logic       last;

    modport source (output valid, status, out_byte, byte_valid, length, last, input ready);
    modport sink   (input valid, status, out_byte, byte_valid, length, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cmq_front.sv =====
// Front part: accepts items, keeps the queue bookkeeping and issues commands.
`default_nettype none

module cmq_front
    import cmq_pkg::*;
#(
    parameter int QUEUE_SLOTS       = 16,
    parameter int MAX_MESSAGE_BYTES = 63
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    cmq_req_if.sink     req,
    output cmd_t        cmd,
    output logic        cmd_valid,
    input  wire logic   cmd_ready
);

    localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int FILL_W = $clog2(QUEUE_SLOTS + 1);

    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              closed_reg, closed_next;
    logic [OFS_W-1:0]  wofs_reg, wofs_next;
    logic              skip_reg, skip_next;

    logic              accept;
    logic              ends;
    logic              store;
    logic [OFS_W-1:0]  new_ofs;
    logic [6:0]        bs_cap;

    assign req.ready = cmd_ready;
    assign cmd_valid = req.valid;
    assign accept    = req.valid && cmd_ready;

    assign ends    = req.end_of_message || (req.data_byte == 8'd0);
    assign store   = (req.data_byte != 8'd0) && (wofs_reg < OFS_W'(MAX_MESSAGE_BYTES));
    assign new_ofs = wofs_reg + OFS_W'(store);
    assign bs_cap  = (req.buf_size > RECV_CAP) ? RECV_CAP : req.buf_size;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        closed_next = closed_reg;
        wofs_next   = wofs_reg;
        skip_next   = skip_reg;

        cmd.kind      = CMD_RESULT;
        cmd.status    = STAT_OK;
        cmd.length    = '0;
        cmd.byte_we   = 1'b0;
        cmd.byte_addr = MEM_ADDR_W'(MEM_ADDR_W'(tail_reg) * MEM_ADDR_W'(MAX_MESSAGE_BYTES)
                        + MEM_ADDR_W'(wofs_reg));
        cmd.byte_data = req.data_byte;
        cmd.len_we    = 1'b0;
        cmd.slot      = SLOT_IDX_W'(tail_reg);
        cmd.cap       = OFS_W'(bs_cap - 7'd1);

        case (req.func)
            FUNC_SEND:
            begin
                if (closed_reg)
                begin
                    wofs_next  = '0;
                    skip_next  = 1'b0;
                    cmd.status = STAT_CLOSED;
                end
                else if (skip_reg)
                begin
                    // Tail of a truncated message: consume until it ends.
                    if (ends)
                    begin
                        skip_next = 1'b0;
                    end
                end
                else if (fill_reg == FILL_W'(QUEUE_SLOTS))
                begin
                    wofs_next  = '0;
                    cmd.status = STAT_FULL;
                end
                else
                begin
                    cmd.byte_we = store;
                    if (ends || (new_ofs >= OFS_W'(MAX_MESSAGE_BYTES)))
                    begin
                        skip_next  = !ends;
                        cmd.length = new_ofs;
                        cmd.len_we = 1'b1;
                        tail_next  = (tail_reg == SLOT_W'(QUEUE_SLOTS - 1)) ? '0
                                     : tail_reg + SLOT_W'(1);
                        fill_next  = fill_reg + FILL_W'(1);
                        wofs_next  = '0;
                    end
                    else
                    begin
                        wofs_next = new_ofs;
                    end
                end
            end
            FUNC_RECV:
            begin
                if (req.buf_size == 7'd0)
                begin
                    cmd.status = STAT_OK;
                end
                else if (fill_reg == '0)
                begin
                    cmd.status = closed_reg ? STAT_CLOSED : STAT_EMPTY;
                end
                else
                begin
                    cmd.kind  = CMD_RECV;
                    cmd.slot  = SLOT_IDX_W'(head_reg);
                    head_next = (head_reg == SLOT_W'(QUEUE_SLOTS - 1)) ? '0
                                : head_reg + SLOT_W'(1);
                    fill_next = fill_reg - FILL_W'(1);
                end
            end
            FUNC_CLOSE:
            begin
                closed_next = 1'b1;
            end
            default:
            begin
                cmd.status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            closed_reg <= 1'b0;
            wofs_reg   <= '0;
            skip_reg   <= 1'b0;
        end
        else if (accept)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            closed_reg <= closed_next;
            wofs_reg   <= wofs_next;
            skip_reg   <= skip_next;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_SLOTS))
        else $error("fill count exceeds the number of slots");

    a_ofs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wofs_reg < OFS_W'(MAX_MESSAGE_BYTES))
        else $error("write offset reached the message limit without a commit");

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        closed_reg |=> closed_reg)
        else $error("closed queue reopened");

endmodule

`default_nettype wire

// ===== rtl/core/cmq_cmd_fifo.sv =====
// Short command queue between the front and back parts.
`default_nettype none

module cmq_cmd_fifo
    import cmq_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cmd_t  push_cmd,
    input  wire logic  push_valid,
    output logic       push_ready,
    output cmd_t       pop_cmd,
    output logic       pop_valid,
    input  wire logic  pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cmq_back.sv =====
// Back part: slot memories, receive streaming and the output register.
`default_nettype none

module cmq_back
    import cmq_pkg::*;
#(
    parameter int QUEUE_SLOTS       = 16,
    parameter int MAX_MESSAGE_BYTES = 63
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   cmd,
    input  wire logic   cmd_valid,
    output logic        cmd_ready,
    cmq_rsp_if.source   rsp
);

    localparam int SLOT_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int DEPTH  = QUEUE_SLOTS * MAX_MESSAGE_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LEN    = 3'b010,
        ST_STREAM = 3'b100
    } state_t;

    logic [7:0]        byte_mem [DEPTH];
    logic [OFS_W-1:0]  len_mem  [QUEUE_SLOTS];

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [OFS_W-1:0]  cap_reg, cap_next;
    logic [OFS_W-1:0]  n_reg, n_next;
    logic [OFS_W-1:0]  cnt_reg, cnt_next;
    logic              q_vld_reg, q_vld_next;
    logic              q_last_reg, q_last_next;
    logic              out_vld_reg, out_vld_next;
    res_t              out_reg, out_next;

    logic [7:0]        byte_q;
    logic [OFS_W-1:0]  len_q;
    logic              byte_re, len_re;
    logic [ADDR_W-1:0] rd_addr;
    logic [OFS_W-1:0]  len_lim, n_calc;
    logic              out_free, move_q, issue;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign move_q    = q_vld_reg && out_free;
    assign issue     = (state_reg == ST_STREAM) && (!q_vld_reg || move_q);
    assign rd_addr   = ADDR_W'(base_reg + ADDR_W'(cnt_reg));
    assign len_lim   = (len_q > OFS_W'(MAX_MESSAGE_BYTES)) ? OFS_W'(MAX_MESSAGE_BYTES) : len_q;
    assign n_calc    = (len_lim > cap_reg) ? cap_reg : len_lim;
    assign cmd_ready = (state_reg == ST_IDLE) && !q_vld_reg
                       && ((cmd.kind == CMD_RECV) || out_free);
    assign byte_re   = issue;
    assign len_re    = cmd_valid && cmd_ready && (cmd.kind == CMD_RECV);

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        cap_next     = cap_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        q_vld_next   = q_vld_reg;
        q_last_next  = q_last_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        out_next     = out_reg;

        if (move_q)
        begin
            out_vld_next        = 1'b1;
            out_next.status     = STAT_OK;
            out_next.out_byte   = byte_q;
            out_next.byte_valid = 1'b1;
            out_next.length     = n_reg;
            out_next.last       = q_last_reg;
            q_vld_next          = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd_ready)
                begin
                    if (cmd.kind == CMD_RECV)
                    begin
                        base_next  = ADDR_W'(ADDR_W'(cmd.slot[SLOT_W-1:0])
                                     * ADDR_W'(MAX_MESSAGE_BYTES));
                        cap_next   = cmd.cap;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        out_vld_next        = 1'b1;
                        out_next.status     = cmd.status;
                        out_next.out_byte   = 8'd0;
                        out_next.byte_valid = 1'b0;
                        out_next.length     = cmd.length;
                        out_next.last       = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                if (n_calc == '0)
                begin
                    // Nothing to deliver: one empty result, the slot is freed anyway.
                    if (out_free)
                    begin
                        out_vld_next        = 1'b1;
                        out_next.status     = STAT_OK;
                        out_next.out_byte   = 8'd0;
                        out_next.byte_valid = 1'b0;
                        out_next.length     = '0;
                        out_next.last       = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    n_next     = n_calc;
                    cnt_next   = '0;
                    state_next = ST_STREAM;
                end
            end
            ST_STREAM:
            begin
                if (issue)
                begin
                    q_vld_next  = 1'b1;
                    q_last_next = (OFS_W'(cnt_reg + OFS_W'(1)) == n_reg);
                    cnt_next    = cnt_reg + OFS_W'(1);
                    if (OFS_W'(cnt_reg + OFS_W'(1)) == n_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && cmd.byte_we)
        begin
            byte_mem[ADDR_W'(cmd.byte_addr)] <= cmd.byte_data;
        end
        if (byte_re)
        begin
            byte_q <= byte_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && cmd.len_we)
        begin
            len_mem[cmd.slot[SLOT_W-1:0]] <= cmd.length;
        end
        if (len_re)
        begin
            len_q <= len_mem[cmd.slot[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        cap_reg  <= cap_next;
        n_reg    <= n_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
        q_last_reg <= q_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            q_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            q_vld_reg   <= q_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.out_byte   = out_reg.out_byte;
    assign rsp.byte_valid = out_reg.byte_valid;
    assign rsp.length     = out_reg.length;
    assign rsp.last       = out_reg.last;

endmodule

`default_nettype wire

// ===== rtl/core/closable_message_ring_queue_top.sv =====
// Top level of the closable message ring queue.
// A send, close or refused item gives its single result via the command queue and the output
// register. A receive's first byte passes the command queue, length read, byte read and output
// register; later bytes follow one per cycle while ready is high. Throughput: one input item per
// cycle while the four-entry command queue has room; the back part runs one command at a time.
// Reset clears indices, fill counts, flags and handshakes; not slot memories or stream counters.
`default_nettype none

module closable_message_ring_queue_top
    import cmq_pkg::*;
#(
    parameter int QUEUE_SLOTS       = 16,
    parameter int MAX_MESSAGE_BYTES = 63
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cmq_req_if.sink    req,
    cmq_rsp_if.source  rsp
);

    // The front part owns all queue bookkeeping (head, tail, fill count, close flag,
    // write offset and truncation state) and settles each item at its transfer. It turns
    // the item into one command: either a finished result, possibly with a byte or length
    // write into slot storage, or a receive of a given slot with a byte limit.
    cmd_t front_cmd;
    logic front_valid;
    logic front_ready;

    // Commands waiting for the back part; this lets senders keep streaming bytes while a
    // receive is still delivering its message.
    cmd_t back_cmd;
    logic back_valid;
    logic back_ready;

    cmq_front #(
        .QUEUE_SLOTS       (QUEUE_SLOTS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    cmq_cmd_fifo #(
        .DEPTH (4)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // The back part executes commands in order, so a slot is always written before a
    // later receive reads it. Message bytes leave through a registered memory read and
    // an output register, one transfer per cycle when the receiver keeps ready high.
    cmq_back #(
        .QUEUE_SLOTS       (QUEUE_SLOTS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
